[rtl/rrq_pkg.sv]
// Shared types and codes for the ranked ready queue.
package rrq_pkg;

	// Operation codes
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_POP    = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_SEARCH = 3'd4;

	// Result status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_INVALID  = 3'd1;
	localparam logic [2:0] STAT_DUP      = 3'd2;
	localparam logic [2:0] STAT_EMPTY    = 3'd3;
	localparam logic [2:0] STAT_NOTFOUND = 3'd4;
	localparam logic [2:0] STAT_FULL     = 3'd5;

	// One stored queue entry
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] rank;
	} entry_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_FILL,
		S_RESP
	} rrq_state_t;

endpackage

[rtl/rrq_ram.sv]
// Entry store: one write port, one read port, registered read data.
module rrq_ram
	import rrq_pkg::*;
#(
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/ranked_ready_queue_top.sv]
// From start to done: a scan of the n entries queued, a decide step, a shift of the k entries moved,
// a fill and a response; no scan on an empty queue, no shift when k is 0, fill for inserts only.
// The worst case is a head insert/removal near full, which makes both RAM walks, scan and shift.
// start is taken again the cycle after done.
// The result is a one-cycle done strobe that the receiver cannot stall.
// Reset empties the queue (occupancy 0); the entry RAM is not cleared.
module ranked_ready_queue_top
	import rrq_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [15:0] elem_id,
	input  logic signed [31:0] rank,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] out_id,
	output logic signed [31:0] out_rank,
	output logic [5:0]  count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);

	rrq_state_t state_q, state_nxt;

	logic [OW-1:0] occ_q;
	logic [2:0]    op_q;
	logic [15:0]   id_q;
	logic [31:0]   rank_q;

	// read sweep pointer
	logic [AW-1:0] src_q, src_end_q;
	logic          src_down_q, iss_q;

	// read pipeline
	logic          rd_vld_s1;
	logic [AW-1:0] addr_s1;

	// scan results
	logic          hit_q, gt_q;
	logic [AW-1:0] hit_pos_q, gt_pos_q;
	entry_t        hit_data_q;

	// decided operation
	logic          ins_q;
	logic [AW-1:0] pos_q;
	logic [2:0]    res_status_q;
	logic [15:0]   res_id_q;
	logic [31:0]   res_rank_q;

	// RAM ports
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t        rd_data, wr_data;

	logic accept;
	logic scan_done, shift_done;
	logic [AW-1:0] last_addr;

	logic          d_ins, d_del, d_shift;
	logic [AW-1:0] d_pos;
	logic [2:0]    d_status;
	logic [15:0]   d_id;
	logic [31:0]   d_rank;

	rrq_ram #(
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept     = start && !busy;
	assign last_addr  = AW'(occ_q - 1'b1);
	assign scan_done  = (state_q == S_SCAN) && rd_vld_s1 && (addr_s1 == last_addr);
	assign shift_done = (state_q == S_SHIFT) && rd_vld_s1 && (addr_s1 == src_end_q);

	// decision on the scanned queue
	always_comb begin
		d_status = STAT_OK;
		d_ins    = 1'b0;
		d_del    = 1'b0;
		d_pos    = hit_pos_q;
		d_id     = '0;
		d_rank   = '0;
		case (op_q)
			OP_APPEND, OP_INSERT: begin
				if (id_q == '0) begin
					d_status = STAT_INVALID;
				end else if (hit_q) begin
					d_status = STAT_DUP;
				end else if (occ_q == OW'(CAPACITY)) begin
					d_status = STAT_FULL;
				end else begin
					d_ins = 1'b1;
					d_pos = (op_q == OP_INSERT && gt_q) ? gt_pos_q : AW'(occ_q);
				end
			end
			OP_POP, OP_REMOVE, OP_SEARCH: begin
				if (occ_q == '0) begin
					d_status = STAT_EMPTY;
				end else if (op_q != OP_POP && id_q == '0) begin
					d_status = STAT_INVALID;
				end else if (!hit_q) begin
					d_status = STAT_NOTFOUND;
				end else begin
					d_id   = hit_data_q.id;
					d_rank = hit_data_q.rank;
					d_del  = (op_q != OP_SEARCH);
				end
			end
			default: begin
				d_status = STAT_INVALID;
			end
		endcase
		d_shift = d_ins ? (d_pos != AW'(occ_q)) : (d_del && (d_pos != last_addr));
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = (occ_q != '0) ? S_SCAN : S_DECIDE;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (d_shift) begin
					state_nxt = S_SHIFT;
				end else if (d_ins) begin
					state_nxt = S_FILL;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_nxt = ins_q ? S_FILL : S_RESP;
				end
			end
			S_FILL:  state_nxt = S_RESP;
			S_RESP:  state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs and RAM controls
	always_comb begin
		busy    = (state_q != S_IDLE);
		done    = (state_q == S_RESP);
		rd_en   = (state_q == S_SCAN || state_q == S_SHIFT) && iss_q;
		rd_addr = src_q;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = rd_data;
		case (state_q)
			S_SHIFT: begin
				// moved entries go one slot up for an insert, one down for a removal
				wr_en   = rd_vld_s1;
				wr_addr = ins_q ? AW'(addr_s1 + 1'b1) : AW'(addr_s1 - 1'b1);
			end
			S_FILL: begin
				wr_en        = 1'b1;
				wr_data.id   = id_q;
				wr_data.rank = rank_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign status   = res_status_q;
	assign out_id   = res_id_q;
	assign out_rank = res_rank_q;
	assign count    = 6'(occ_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			iss_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			gt_q      <= 1'b0;
			ins_q     <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= rd_en;

			// sweep stops once the last address is issued
			if (rd_en && src_q == src_end_q) begin
				iss_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						gt_q  <= 1'b0;
						iss_q <= (occ_q != '0);
					end
				end
				S_SCAN: begin
					if (rd_vld_s1) begin
						if (!hit_q && ((op_q == OP_POP) ? (addr_s1 == '0)
						                                : (rd_data.id == id_q))) begin
							hit_q <= 1'b1;
						end
						if (!gt_q && ($signed(rd_data.rank) > $signed(rank_q))) begin
							gt_q <= 1'b1;
						end
					end
				end
				S_DECIDE: begin
					ins_q <= d_ins;
					iss_q <= d_shift;
					if (d_del && !d_shift) begin
						occ_q <= occ_q - 1'b1;
					end
				end
				S_SHIFT: begin
					if (shift_done && !ins_q) begin
						occ_q <= occ_q - 1'b1;
					end
				end
				S_FILL: begin
					occ_q <= occ_q + 1'b1;
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;

		if (rd_en) begin
			src_q <= src_down_q ? AW'(src_q - 1'b1) : AW'(src_q + 1'b1);
		end

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= op;
					id_q       <= elem_id;
					rank_q     <= rank;
					src_q      <= '0;
					src_end_q  <= last_addr;
					src_down_q <= 1'b0;
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					if (!hit_q && ((op_q == OP_POP) ? (addr_s1 == '0)
					                                : (rd_data.id == id_q))) begin
						hit_pos_q  <= addr_s1;
						hit_data_q <= rd_data;
					end
					if (!gt_q && ($signed(rd_data.rank) > $signed(rank_q))) begin
						gt_pos_q <= addr_s1;
					end
				end
			end
			S_DECIDE: begin
				pos_q        <= d_pos;
				res_status_q <= d_status;
				res_id_q     <= d_id;
				res_rank_q   <= d_rank;
				// insert walks down from the tail, removal walks up past the hole
				src_down_q   <= d_ins;
				src_q        <= d_ins ? last_addr : AW'(d_pos + 1'b1);
				src_end_q    <= d_ins ? d_pos : last_addr;
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// occupancy stays within the store
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(CAPACITY))
		else $error("occupancy above capacity");

	// a read and a write in the same cycle never hit the same entry
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write to the same entry");

	// the RAM is written only while moving or filling entries
	a_wr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHIFT || state_q == S_FILL))
		else $error("RAM write outside shift or fill");

	// a result strobe lasts one cycle and frees the block
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("done not a single pulse");

	// occupancy only moves by one, and only during a transaction
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> ($past(busy) &&
			((occ_q == $past(occ_q) + 1'b1) || (occ_q == $past(occ_q) - 1'b1))))
		else $error("occupancy jumped");

endmodule
